### hdl/wjd_pkg.sv
// wjd_pkg: shared constants, types and codes of the window jump detector
// no dependencies
package wjd_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int WIN_W       = 7;
    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = 20;
    localparam int CNT_W       = 21;
    localparam int MAX_SAMPLES = 1 << IDX_W;
    localparam int RING_DEPTH  = 2 * MAX_WINDOW;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int SUM_W       = 22;
    localparam int SQ_W        = 38;
    localparam int SCALE_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int STATUS_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW     = 2'd0,
        CFG_JUMP_SCALE = 2'd1,
        CFG_SPREAD     = 2'd2,
        CFG_MIN_SEP    = 2'd3
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_GROUP    = 3'd0,
        ST_END_JUMP = 3'd1,
        ST_END_NONE = 3'd2,
        ST_SHORT    = 3'd3,
        ST_LONG     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_DRAIN, S_M1, S_M2, S_M3, S_M4, S_M5, S_CMP, S_DEC
    } t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_item;

    typedef struct packed {
        logic [WIN_W-1:0]   window;
        logic [SCALE_W-1:0] jump_scale;
        logic [SCALE_W-1:0] spread_scale;
        logic [IDX_W-1:0]   min_sep;
    } t_cfg;

endpackage

### hdl/wjd_ram.sv
// wjd_ram: generic ram, one write port, two registered read ports
// no dependencies
module wjd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

### hdl/wjd_front.sv
// wjd_front: input side, short queue of accepted samples
// depends on wjd_pkg
module wjd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wjd_pkg::t_item i_item,
    output logic          o_avail,
    output wjd_pkg::t_item o_head,
    input  logic          i_pop
);
    import wjd_pkg::*;

    t_item                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp, r_rp;
    logic [QUEUE_AW:0]    r_cnt;
    logic                 push;

    assign o_ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_q[r_rp];
    assign push    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= i_item;
                r_wp      <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(i_pop);
        end
    end
endmodule

### hdl/wjd_back.sv
// wjd_back: window sums over the sample ring, threshold tests, grouping
// depends on wjd_pkg and wjd_ram
module wjd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wjd_pkg::t_cfg               i_cfg,
    input  logic                        i_avail,
    input  wjd_pkg::t_item              i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [wjd_pkg::IDX_W-1:0]   o_jump_index,
    output logic [wjd_pkg::STATUS_W-1:0] o_status
);
    import wjd_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [SAMPLE_W-1:0] r_ref, n_ref;
    logic [IDX_W-1:0]    r_best_pos, n_best_pos;
    logic [SUM_W-1:0]    r_best_str, n_best_str;
    logic                r_open, n_open;
    logic [IDX_W-1:0]    r_j, n_j;
    logic [WIN_W-1:0]    r_w, n_w;
    logic [WIN_W-1:0]    r_k, n_k;
    logic                r_acc_v, n_acc_v;
    logic [SUM_W-1:0]    r_sa, n_sa, r_sb, n_sb;
    logic [SQ_W-1:0]     r_sq, n_sq;
    logic [43:0]         r_pa, n_pa, r_pb, n_pb, r_var, n_var;
    logic [22:0]         r_lim1, n_lim1;
    logic [38:0]         r_lim, n_lim;
    logic [77:0]         r_sqlim, n_sqlim;
    logic                r_jump_ok, n_jump_ok, r_spread_ok, n_spread_ok;
    logic                r_out_v, n_out_v;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    t_status             r_out_st, n_out_st;

    logic [WIN_W-1:0]    w_eff;
    logic                pop_ok, ovf_now, tested;
    logic [CNT_W-1:0]    j_next;
    logic                ram_we;
    logic [RING_AW-1:0]  addr_a, addr_b;
    logic [SAMPLE_W-1:0] rd_a, rd_b;
    logic [SUM_W-1:0]    hi_s, lo_s, strength;
    logic [IDX_W-1:0]    pos;
    logic [IDX_W:0]      pos_diff;
    logic                join_grp;

    always_comb begin
        if (i_cfg.window == '0) begin
            w_eff = WIN_W'(1);
        end else if (i_cfg.window > WIN_W'(MAX_WINDOW)) begin
            w_eff = WIN_W'(MAX_WINDOW);
        end else begin
            w_eff = i_cfg.window;
        end
    end

    assign pop_ok  = (r_state == S_IDLE) && i_avail && !r_out_v;
    assign o_pop   = pop_ok;
    assign ovf_now = r_ovf || (r_count >= CNT_W'(MAX_SAMPLES));
    assign j_next  = r_count + 1'b1;
    assign tested  = j_next >= {{(CNT_W-WIN_W-1){1'b0}}, w_eff, 1'b0};
    assign ram_we  = pop_ok && !i_head.last && !ovf_now;
    assign addr_a  = r_j[RING_AW-1:0] - RING_AW'(r_k);
    assign addr_b  = r_j[RING_AW-1:0] - RING_AW'(r_w) - RING_AW'(r_k);

    assign hi_s     = (r_sa > r_sb) ? r_sa : r_sb;
    assign lo_s     = (r_sa > r_sb) ? r_sb : r_sa;
    assign strength = hi_s - lo_s;
    assign pos      = r_j - IDX_W'(r_w) + 1'b1;
    assign pos_diff = {1'b0, pos} - {1'b0, r_best_pos};
    assign join_grp = !pos_diff[IDX_W] && (pos_diff[IDX_W-1:0] <= i_cfg.min_sep);

    wjd_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_count[RING_AW-1:0]),
        .i_wdata   (i_head.sample),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop_ok && !i_head.last && !ovf_now && tested) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:   if (r_k == r_w - 1'b1) n_state = S_DRAIN;
            S_DRAIN: n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_CMP;
            S_CMP:   n_state = S_DEC;
            S_DEC:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_ref       = r_ref;
        n_best_pos  = r_best_pos;
        n_best_str  = r_best_str;
        n_open      = r_open;
        n_j         = r_j;
        n_w         = r_w;
        n_k         = r_k;
        n_acc_v     = 1'b0;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_sq        = r_sq;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_var       = r_var;
        n_lim1      = r_lim1;
        n_lim       = r_lim;
        n_sqlim     = r_sqlim;
        n_jump_ok   = r_jump_ok;
        n_spread_ok = r_spread_ok;
        n_out_v     = r_out_v && !i_ready;
        n_out_idx   = r_out_idx;
        n_out_st    = r_out_st;

        if (r_acc_v) begin
            n_sa = r_sa + SUM_W'(rd_a);
            n_sb = r_sb + SUM_W'(rd_b);
            n_sq = r_sq + SQ_W'({16'b0, rd_b} * {16'b0, rd_b});
        end

        unique case (r_state)
            S_IDLE: begin
                if (pop_ok) begin
                    if (i_head.last) begin
                        n_out_v   = 1'b1;
                        n_out_idx = '0;
                        if (ovf_now) begin
                            n_out_st = ST_LONG;
                        end else if (!tested) begin
                            n_out_st = ST_SHORT;
                        end else if (r_open) begin
                            n_out_st  = ST_END_JUMP;
                            n_out_idx = r_best_pos;
                        end else begin
                            n_out_st = ST_END_NONE;
                        end
                        n_count    = '0;
                        n_ovf      = 1'b0;
                        n_ref      = '0;
                        n_best_pos = '0;
                        n_best_str = '0;
                        n_open     = 1'b0;
                    end else if (ovf_now) begin
                        n_ovf = 1'b1;
                    end else begin
                        if (r_count == '0) n_ref = i_head.sample;
                        n_count = j_next;
                        n_j     = r_count[IDX_W-1:0];
                        n_w     = w_eff;
                        n_k     = '0;
                        n_sa    = '0;
                        n_sb    = '0;
                        n_sq    = '0;
                    end
                end
            end
            S_SUM: begin
                n_acc_v = 1'b1;
                n_k     = r_k + 1'b1;
            end
            S_DRAIN: ;
            S_M1: begin
                n_pa   = 44'({6'b0, r_sq} * {37'b0, r_w});
                n_lim1 = 23'({7'b0, r_ref} * {16'b0, r_w});
            end
            S_M2: begin
                n_pb  = {22'b0, r_sb} * {22'b0, r_sb};
                n_lim = 39'({16'b0, r_lim1} * {23'b0, i_cfg.spread_scale});
            end
            S_M3: begin
                n_var   = r_pa - r_pb;
                n_sqlim = 78'({20'b0, r_lim[19:0]} * {20'b0, r_lim[19:0]});
            end
            S_M4: begin
                n_sqlim = r_sqlim
                        + (78'({21'b0, r_lim[38:20]} * {20'b0, r_lim[19:0]}) << 21);
            end
            S_M5: begin
                n_sqlim   = r_sqlim
                          + (78'({21'b0, r_lim[38:20]} * {21'b0, r_lim[38:20]}) << 40);
                n_jump_ok = {8'b0, hi_s, 8'b0}
                          > 38'({16'b0, lo_s} * {22'b0, i_cfg.jump_scale});
            end
            S_CMP: begin
                n_spread_ok = {18'b0, r_var, 16'b0} < r_sqlim;
            end
            S_DEC: begin
                if (r_jump_ok && r_spread_ok) begin
                    if (!r_open) begin
                        n_open     = 1'b1;
                        n_best_pos = pos;
                        n_best_str = strength;
                    end else if (join_grp) begin
                        if (strength > r_best_str) begin
                            n_best_pos = pos;
                            n_best_str = strength;
                        end
                    end else begin
                        n_out_v    = 1'b1;
                        n_out_idx  = r_best_pos;
                        n_out_st   = ST_GROUP;
                        n_best_pos = pos;
                        n_best_str = strength;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_ref      <= '0;
            r_best_pos <= '0;
            r_best_str <= '0;
            r_open     <= 1'b0;
            r_acc_v    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_ref      <= n_ref;
            r_best_pos <= n_best_pos;
            r_best_str <= n_best_str;
            r_open     <= n_open;
            r_acc_v    <= n_acc_v;
            r_out_v    <= n_out_v;
        end
        r_j         <= n_j;
        r_w         <= n_w;
        r_k         <= n_k;
        r_sa        <= n_sa;
        r_sb        <= n_sb;
        r_sq        <= n_sq;
        r_pa        <= n_pa;
        r_pb        <= n_pb;
        r_var       <= n_var;
        r_lim1      <= n_lim1;
        r_lim       <= n_lim;
        r_sqlim     <= n_sqlim;
        r_jump_ok   <= n_jump_ok;
        r_spread_ok <= n_spread_ok;
        r_out_idx   <= n_out_idx;
        r_out_st    <= n_out_st;
    end

    assign o_valid      = r_out_v;
    assign o_jump_index = r_out_idx;
    assign o_status     = r_out_st;
endmodule

### hdl/window_jump_detector_unit.sv
// window_jump_detector_unit: top level, config registers, front queue and back engine
// depends on wjd_pkg, wjd_front, wjd_back
// A sample that is not tested (too early in the series, the last one, or past
// the length limit) is handled in S_IDLE alone; a tested sample goes on to the
// window sum pass over the sample ring in S_SUM (two reads a cycle), then to
// the threshold and grouping steps S_DRAIN, S_M1 to S_M5, S_CMP and S_DEC. A
// two-entry queue takes samples while the engine works, and a result register
// holds the output so a stall there does not block input until the queue fills.
module window_jump_detector_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [wjd_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [wjd_pkg::IDX_W-1:0]      o_jump_index,
    output logic [wjd_pkg::STATUS_W-1:0]   o_status,
    input  logic                           i_cfg_we,
    input  logic [wjd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wjd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wjd_pkg::*;

    t_cfg  r_cfg;
    t_item in_item, head;
    logic  avail, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window       <= WIN_W'(2);
            r_cfg.jump_scale   <= SCALE_W'(333);
            r_cfg.spread_scale <= SCALE_W'(256);
            r_cfg.min_sep      <= IDX_W'(2);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW:     r_cfg.window       <= i_cfg_data[WIN_W-1:0];
                CFG_JUMP_SCALE: r_cfg.jump_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_SPREAD:     r_cfg.spread_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_MIN_SEP:    r_cfg.min_sep      <= i_cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_item.sample = i_sample;
    assign in_item.last   = i_last;

    wjd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_avail (avail),
        .o_head  (head),
        .i_pop   (pop)
    );

    wjd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_avail      (avail),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_jump_index (o_jump_index),
        .o_status     (o_status)
    );
endmodule

### hdl/wjd_checker.sv
// wjd_checker: port level assertions for the window jump detector
// depends on wjd_pkg, bound to window_jump_detector_unit
module wjd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [wjd_pkg::IDX_W-1:0]      o_jump_index,
    input logic [wjd_pkg::STATUS_W-1:0]   o_status
);
    import wjd_pkg::*;

    // a stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_jump_index) && $stable(o_status))
        else $error("output changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_GROUP || o_status == ST_END_JUMP ||
                     o_status == ST_END_NONE || o_status == ST_SHORT ||
                     o_status == ST_LONG))
        else $error("bad status code");

    a_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_END_NONE || o_status == ST_SHORT ||
                    o_status == ST_LONG) |-> o_jump_index == '0)
        else $error("index not zero for end status");

    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
endmodule

bind window_jump_detector_unit wjd_checker u_wjd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_jump_index (o_jump_index),
    .o_status     (o_status)
);

### tb/sv/wjd_checker.sv
`timescale 1ns / 1ps
// wjd_scoreboard: watches the sample, result and config ports of the window jump detector,
// predicts each result and compares it field by field; depends on wjd_pkg
module wjd_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_ready_in,
    input  logic [wjd_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_last,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [wjd_pkg::IDX_W-1:0]      i_jump_index,
    input  logic [wjd_pkg::STATUS_W-1:0]   i_status,
    input  logic                           i_cfg_we,
    input  logic [wjd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wjd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import wjd_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] idx;
        t_status          st;
    } t_jump_result;

    t_jump_result jump_q[$];

    logic [WIN_W-1:0]    win_reg;
    logic [SCALE_W-1:0]  jump_scale, spread_scale;
    logic [IDX_W-1:0]    min_sep;
    logic [SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned         count;
    logic                count_ovf;
    logic [SAMPLE_W-1:0] first_sample;
    logic [IDX_W-1:0]    best_pos;
    logic [SUM_W-1:0]    best_str;
    logic                group_open;

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    task automatic clear_series();
        count      = 0;
        count_ovf  = 1'b0;
        first_sample = '0;
        best_pos   = '0;
        best_str   = '0;
        group_open = 1'b0;
    endtask

    task automatic predict_jump(input logic [SAMPLE_W-1:0] x, input logic last);
        int unsigned      w, j, pos;
        longint unsigned  sa, sb, sq, v, hi, lo;
        bit [127:0]       var_scaled, lim, lim_sq;
        logic [SUM_W-1:0] str;
        t_jump_result     r;
        w = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
        j = count;
        if (j >= MAX_SAMPLES) count_ovf = 1'b1;
        if (last) begin
            r.idx = '0;
            if (count_ovf) r.st = ST_LONG;
            else if (j + 1 < 2 * w) r.st = ST_SHORT;
            else if (group_open) begin
                r.idx = best_pos;
                r.st  = ST_END_JUMP;
            end else r.st = ST_END_NONE;
            jump_q = {jump_q, r};
            clear_series();
            return;
        end
        if (count_ovf) return;
        if (j == 0) first_sample = x;
        ring[j % RING_DEPTH] = x;
        count = j + 1;
        if (j + 1 < 2 * w) return;
        sa = 0;
        sb = 0;
        sq = 0;
        for (int k = 0; k < w; k++) begin
            sa += ring[(j - k) % RING_DEPTH];
            v = ring[(j - w - k) % RING_DEPTH];
            sb += v;
            sq += v * v;
        end
        var_scaled = 128'(w * sq - sb * sb) << 16;
        lim        = 128'(w) * first_sample * spread_scale;
        lim_sq     = lim * lim;
        hi = (sa > sb) ? sa : sb;
        lo = (sa > sb) ? sb : sa;
        if (!(var_scaled < lim_sq && hi * 256 > jump_scale * lo)) return;
        pos = j - w + 1;
        str = SUM_W'(hi - lo);
        if (!group_open) begin
            group_open = 1'b1;
            best_pos   = IDX_W'(pos);
            best_str   = str;
        end else if (pos - best_pos <= min_sep) begin
            if (str > best_str) begin
                best_pos = IDX_W'(pos);
                best_str = str;
            end
        end else begin
            r.idx = best_pos;
            r.st  = ST_GROUP;
            jump_q = {jump_q, r};
            best_pos = IDX_W'(pos);
            best_str = str;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_jump_result e;
        if (!i_rst_n) begin
            win_reg      = 7'd2;
            jump_scale   = 16'd333;
            spread_scale = 16'd256;
            min_sep      = 20'd2;
            clear_series();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WINDOW:     win_reg      = i_cfg_data[WIN_W-1:0];
                    CFG_JUMP_SCALE: jump_scale   = i_cfg_data[SCALE_W-1:0];
                    CFG_SPREAD:     spread_scale = i_cfg_data[SCALE_W-1:0];
                    CFG_MIN_SEP:    min_sep      = i_cfg_data[IDX_W-1:0];
                endcase
            end
            if (i_valid && i_ready_in) predict_jump(i_sample, i_last);
            if (i_out_valid && i_out_ready) begin
                if (jump_q.size() == 0) begin
                    report("unexpected result transfer, status", int'(i_status), -1);
                end else begin
                    e = jump_q.pop_front();
                    if (i_jump_index !== e.idx) report("jump_index", i_jump_index, e.idx);
                    if (i_status !== e.st) report("status", i_status, e.st);
                end
            end
        end
        o_pending = jump_q.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for window_jump_detector_unit
// depends on wjd_pkg, window_jump_detector_unit and wjd_scoreboard
module tb;
    import wjd_pkg::*;

    logic                  i_clk, i_rst_n;
    logic                  i_valid, o_ready, i_last;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  o_valid, i_ready;
    logic [IDX_W-1:0]      o_jump_index;
    logic [STATUS_W-1:0]   o_status;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors, pending;
    bit                    calm, hold_req;
    int                    level;

    window_jump_detector_unit uut (.*);

    wjd_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_sample(i_sample), .i_last(i_last),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_jump_index(o_jump_index), .i_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(0, 13)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge i_clk);
            end
        end
    end

    task automatic send(input logic [SAMPLE_W-1:0] s, input logic l);
        i_valid  <= 1'b1;
        i_sample <= s;
        i_last   <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_config(input int w, input int js, input int ss, input int ms);
        int vals [4];
        vals = '{w, js, ss, ms};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= CFG_DATA_W'(vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // piecewise level series with noise and occasional wild samples
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int v;
        if ($urandom_range(0, 9) == 0)
            level = ($urandom_range(0, 1)) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
        if ($urandom_range(0, 19) == 0) return SAMPLE_W'($urandom);
        v = level + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return SAMPLE_W'(v);
    endfunction

    task automatic send_series(input int len);
        level = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 200);
        for (int k = 0; k < len - 1; k++) send(next_sample(), 1'b0);
        send(next_sample(), 1'b1);
    endtask

    initial begin
        int sent, w, wv;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on reset settings, then on one set of edge settings
        for (int k = 0; k < 4; k++) send(16'd100, 1'b0);
        for (int k = 0; k < 4; k++) send(16'd400, 1'b0);
        for (int k = 0; k < 3; k++) send(16'd100, 1'b0);
        send(16'd100, 1'b1);
        for (int k = 0; k < 4; k++) send(16'd0, 1'b0);
        send(16'd0, 1'b1);
        send(16'hffff, 1'b1);
        send(16'hffff, 1'b0);
        send(16'd0, 1'b1);
        settle();
        set_config(0, 0, 65535, 0);
        for (int k = 0; k < 3; k++) send(16'hffff, 1'b0);
        send(16'd1, 1'b0);
        send(16'd0, 1'b1);
        settle();

        // random phases over several settings, the extremes among them
        sent = 0;
        for (int p = 0; p < 12; p++) begin
            case (p)
                0:       wv = 1;
                1:       wv = 64;
                2:       wv = 127;
                3:       wv = 0;
                default: wv = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(0, 127);
            endcase
            set_config(wv,
                       (p == 4) ? 65535 : (p == 5) ? 0 : $urandom_range(256, 900),
                       (p == 6) ? 0 : (p == 7) ? 65535 : $urandom_range(64, 4096),
                       (p == 8) ? 1048575 : (p == 9) ? 0 : $urandom_range(0, 12));
            w = (wv == 0) ? 1 : (wv > 64 ? 64 : wv);
            calm = (p == 11);
            if (p == 2) hold_req = 1'b1;
            for (int s = 0; s < 8 && sent < 75 * (p + 1); s++) begin
                int len;
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2 * w)
                                                  : $urandom_range(2 * w, 2 * w + 60);
                send_series(len);
                sent += len;
            end
            settle();
        end

        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
